### hdl/tsmr_pkg.sv
// ----------------------------------------------------------------------------
// tsmr_pkg
// Shared types and constants of the track segment map recorder.
// ----------------------------------------------------------------------------
`default_nettype none

package tsmr_pkg;

  localparam int PULSE_W = 24;   // pulse counts and stored lengths
  localparam int FACT_W  = 24;   // Q8.16 conversion factors
  localparam int RLIM_W  = 27;   // radius threshold
  localparam int PWR_W   = 16;   // drive power
  localparam int LONG_W  = 23;   // long straight threshold
  localparam int Q_SHIFT = 16;

  // Shared multiplier operand widths: the radius check multiplies
  // (limit + 1) by |difference|, which sets both operand widths.
  localparam int MUL_A_W = RLIM_W + 1;
  localparam int MUL_B_W = PULSE_W + 1;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  typedef enum logic [2:0] {
    REG_MM_PER_PULSE  = 3'd0,
    REG_PULSES_PER_MM = 3'd1,
    REG_RADIUS_LIMIT  = 3'd2,
    REG_STRAIGHT_PWR  = 3'd3,
    REG_CURVE_PWR     = 3'd4,
    REG_LONG_MM       = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    FUNC_CLEAR   = 3'd0,
    FUNC_RECORD  = 3'd1,
    FUNC_REWIND  = 3'd2,
    FUNC_QUERY   = 3'd3,
    FUNC_ADVANCE = 3'd4
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_L,
    ST_MUL_R,
    ST_SAT_R,
    ST_SUMDIF,
    ST_RATIO,
    ST_STORE,
    ST_QMUL,
    ST_QOUT
  } state_t;

endpackage

`default_nettype wire

### hdl/tsmr_ram.sv
// ----------------------------------------------------------------------------
// tsmr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tsmr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### hdl/tsmr_mul.sv
// ----------------------------------------------------------------------------
// tsmr_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module tsmr_mul (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [tsmr_pkg::MUL_A_W-1:0]  a,
  input  wire logic [tsmr_pkg::MUL_B_W-1:0]  b,
  output logic      [tsmr_pkg::MUL_P_W-1:0]  prod
);
  import tsmr_pkg::*;

  logic [MUL_P_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= MUL_P_W'(a) * MUL_P_W'(b);
    end
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

### hdl/track_segment_map_recorder.sv
// ----------------------------------------------------------------------------
// track_segment_map_recorder
// A record into a map with room steps through the states MUL_L, MUL_R, SAT_R,
// SUMDIF, RATIO and STORE between request and result strobe, a query of a
// stored segment through QMUL and QOUT; every other request is answered from
// the idle state. Busy stays high until the result strobe, so a record or a
// stored query occupies the block until then; any other request can be
// followed by a new one on the next cycle. The shared multiplier and its sequencer set this order.
// Reset: synchronous, active low; the map is empty and the replay index 0.
// The result strobe lasts one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module track_segment_map_recorder #(
  parameter int MAP_DEPTH = 64,
  parameter int CNT_W     = $clog2(MAP_DEPTH + 1),
  parameter int IDX_W     = $clog2(MAP_DEPTH)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,

  // Request channel
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [2:0]                    in_func,
  input  wire logic [tsmr_pkg::PULSE_W-1:0]  in_left_pulses,
  input  wire logic [tsmr_pkg::PULSE_W-1:0]  in_right_pulses,

  // Result channel
  output logic                               out_valid,
  output logic                               out_status,
  output logic                               out_reset_encoders,
  output logic      [tsmr_pkg::PWR_W-1:0]    out_target_power,
  output logic                               out_segment_done,
  output logic                               out_is_straight,
  output logic                               out_is_long_straight,
  output logic      [tsmr_pkg::PULSE_W-1:0]  out_segment_mm,
  output logic      [tsmr_pkg::PULSE_W-1:0]  out_segment_pulses,
  output logic      [CNT_W-1:0]              out_recorded_count,
  output logic      [IDX_W-1:0]              out_current_index,

  // Configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tsmr_pkg::APB_AW-1:0]   paddr,
  input  wire logic [tsmr_pkg::APB_DW-1:0]   pwdata,
  output logic      [tsmr_pkg::APB_DW-1:0]   prdata,
  output logic                               pready
);
  import tsmr_pkg::*;

  localparam int RAM_W = 2 * PULSE_W + 1;

  // Saturate a pulse-to-millimetre product magnitude to the 24-bit signed range.
  function automatic logic [PULSE_W-1:0] sat_mm(input logic [30:0] p, input logic neg);
    logic [PULSE_W-1:0] res;
    if (!neg) begin
      res = (p > 31'd8388607) ? 24'h7FFFFF : p[PULSE_W-1:0];
    end else begin
      res = (p >= 31'd8388608) ? 24'h800000 : (~p[PULSE_W-1:0] + 24'd1);
    end
    return res;
  endfunction

  function automatic logic [PULSE_W-1:0] mag24(input logic [PULSE_W-1:0] v);
    return v[PULSE_W-1] ? (~v + 24'd1) : v;
  endfunction

  // Halve a 25-bit signed value, truncating toward zero.
  function automatic logic [PULSE_W-1:0] half25(input logic [PULSE_W:0] s);
    logic [PULSE_W:0] t;
    t = s + {{PULSE_W{1'b0}}, s[PULSE_W]};
    return t[PULSE_W:1];
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers. pready is always high, so a write completes in
  // its access cycle.
  // --------------------------------------------------------------------------
  logic [FACT_W-1:0] mm_per_pulse_r, pulses_per_mm_r;
  logic [RLIM_W-1:0] radius_limit_r;
  logic [PWR_W-1:0]  straight_pwr_r, curve_pwr_r;
  logic [LONG_W-1:0] long_mm_r;
  logic              cfg_we;
  reg_idx_t          cfg_sel;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite & pready;
  assign cfg_sel = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mm_per_pulse_r  <= 24'd21955;
      pulses_per_mm_r <= 24'd195625;
      radius_limit_r  <= 27'd1000;
      straight_pwr_r  <= 16'd800;
      curve_pwr_r     <= 16'd500;
      long_mm_r       <= 23'd1000;
    end else if (cfg_we) begin
      unique case (cfg_sel)
        REG_MM_PER_PULSE:  mm_per_pulse_r  <= pwdata[FACT_W-1:0];
        REG_PULSES_PER_MM: pulses_per_mm_r <= pwdata[FACT_W-1:0];
        REG_RADIUS_LIMIT:  radius_limit_r  <= pwdata[RLIM_W-1:0];
        REG_STRAIGHT_PWR:  straight_pwr_r  <= pwdata[PWR_W-1:0];
        REG_CURVE_PWR:     curve_pwr_r     <= pwdata[PWR_W-1:0];
        REG_LONG_MM:       long_mm_r       <= pwdata[LONG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_MM_PER_PULSE:  prdata = APB_DW'(mm_per_pulse_r);
      REG_PULSES_PER_MM: prdata = APB_DW'(pulses_per_mm_r);
      REG_RADIUS_LIMIT:  prdata = APB_DW'(radius_limit_r);
      REG_STRAIGHT_PWR:  prdata = APB_DW'(straight_pwr_r);
      REG_CURVE_PWR:     prdata = APB_DW'(curve_pwr_r);
      REG_LONG_MM:       prdata = APB_DW'(long_mm_r);
      default:           prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer state and datapath registers.
  // --------------------------------------------------------------------------
  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [PULSE_W-1:0] l_r, l_nxt, r_r, r_nxt;
  logic [PULSE_W-1:0] mml_r, mml_nxt, mmr_r, mmr_nxt;
  logic [MUL_A_W-2:0] num_r, num_nxt;      // |sum| * 6, 27 bits
  logic [PULSE_W:0]   den_r, den_nxt;      // |diff|, zero taken as one
  logic [PULSE_W-1:0] avg_mm_r, avg_mm_nxt, avg_p_r, avg_p_nxt;
  logic [PULSE_W-1:0] seg_mm_r, seg_mm_nxt, seg_p_r, seg_p_nxt;
  logic               seg_flag_r, seg_flag_nxt;

  logic               o_status_r, o_status_nxt, o_rst_r, o_rst_nxt;
  logic [PWR_W-1:0]   o_power_r, o_power_nxt;
  logic               o_done_r, o_done_nxt, o_str_r, o_str_nxt, o_lng_r, o_lng_nxt;
  logic [PULSE_W-1:0] o_mm_r, o_mm_nxt, o_p_r, o_p_nxt;
  logic [CNT_W-1:0]   o_cnt_r;
  logic [IDX_W-1:0]   o_idx_r;

  // Shared multiplier and map memory connections.
  logic               mul_en;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;
  logic               ram_we;
  logic [RAM_W-1:0]   ram_wdata, ram_rdata;

  tsmr_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (mul_p)
  );

  // Each entry holds {straight flag, average pulses, average millimetres}.
  tsmr_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAP_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[IDX_W-1:0]),
    .wdata (ram_wdata),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  // Values that the sequencer derives from the product and the stored entry.
  logic [30:0]        q_mag;               // product >> 16
  logic [PULSE_W:0]   sum_w, diff_w, sum_mag, diff_mag;
  logic [PULSE_W:0]   lr_sum;
  logic signed [32:0] cur_s, target_s;
  logic               straight_w;

  assign q_mag  = mul_p[Q_SHIFT +: 31];
  assign sum_w  = {mml_r[PULSE_W-1], mml_r} + {mmr_r[PULSE_W-1], mmr_r};
  assign diff_w = {mml_r[PULSE_W-1], mml_r} - {mmr_r[PULSE_W-1], mmr_r};
  assign sum_mag  = sum_w[PULSE_W] ? (~sum_w + 25'd1) : sum_w;
  assign diff_mag = diff_w[PULSE_W] ? (~diff_w + 25'd1) : diff_w;
  assign lr_sum = {l_r[PULSE_W-1], l_r} + {r_r[PULSE_W-1], r_r};

  // floor(num / den) > limit is the same as num >= (limit + 1) * den.
  assign straight_w = (cnt_r != '0) && ({{(MUL_P_W - MUL_A_W + 1){1'b0}}, num_r} >= mul_p);

  // The write data carries the straight decision made in the store cycle.
  assign ram_wdata = {straight_w, avg_p_r, avg_mm_r};

  // Current average against target = stored mm * pulses_per_mm, sign restored.
  assign cur_s    = 33'(signed'(half25(lr_sum)));
  assign target_s = seg_mm_r[PULSE_W-1] ? -$signed({2'b00, q_mag}) : $signed({2'b00, q_mag});

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    out_valid_nxt = 1'b0;
    l_nxt         = l_r;
    r_nxt         = r_r;
    mml_nxt       = mml_r;
    mmr_nxt       = mmr_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    avg_mm_nxt    = avg_mm_r;
    avg_p_nxt     = avg_p_r;
    seg_mm_nxt    = seg_mm_r;
    seg_p_nxt     = seg_p_r;
    seg_flag_nxt  = seg_flag_r;
    o_status_nxt  = 1'b0;
    o_rst_nxt     = 1'b0;
    o_power_nxt   = '0;
    o_done_nxt    = 1'b0;
    o_str_nxt     = 1'b0;
    o_lng_nxt     = 1'b0;
    o_mm_nxt      = '0;
    o_p_nxt       = '0;
    mul_en        = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    ram_we        = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          l_nxt = in_left_pulses;
          r_nxt = in_right_pulses;
          unique case (func_t'(in_func))
            FUNC_CLEAR: begin
              cnt_nxt       = '0;
              idx_nxt       = '0;
              out_valid_nxt = 1'b1;
            end
            FUNC_RECORD: begin
              if (cnt_r >= CNT_W'(MAP_DEPTH)) begin
                o_status_nxt  = 1'b1;
                out_valid_nxt = 1'b1;
              end else begin
                state_nxt = ST_MUL_L;
              end
            end
            FUNC_REWIND: begin
              idx_nxt       = '0;
              o_rst_nxt     = 1'b1;
              out_valid_nxt = 1'b1;
            end
            FUNC_QUERY: begin
              // The map memory reads entry idx_r during this cycle.
              if (CNT_W'(idx_r) >= cnt_r) begin
                o_done_nxt    = 1'b1;
                out_valid_nxt = 1'b1;
              end else begin
                state_nxt = ST_QMUL;
              end
            end
            FUNC_ADVANCE: begin
              if ((CNT_W'(idx_r) + CNT_W'(1)) < cnt_r) begin
                idx_nxt = idx_r + IDX_W'(1);
              end
              out_valid_nxt = 1'b1;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_MUL_L: begin
        mul_en    = 1'b1;
        mul_a     = MUL_A_W'(mm_per_pulse_r);
        mul_b     = MUL_B_W'(mag24(l_r));
        state_nxt = ST_MUL_R;
      end
      ST_MUL_R: begin
        mul_en    = 1'b1;
        mul_a     = MUL_A_W'(mm_per_pulse_r);
        mul_b     = MUL_B_W'(mag24(r_r));
        mml_nxt   = sat_mm(q_mag, l_r[PULSE_W-1]);
        state_nxt = ST_SAT_R;
      end
      ST_SAT_R: begin
        mmr_nxt   = sat_mm(q_mag, r_r[PULSE_W-1]);
        state_nxt = ST_SUMDIF;
      end
      ST_SUMDIF: begin
        num_nxt    = (MUL_A_W - 1)'({sum_mag, 2'b00}) + (MUL_A_W - 1)'({sum_mag, 1'b0});
        den_nxt    = (diff_w == '0) ? (PULSE_W + 1)'(1) : diff_mag;
        avg_mm_nxt = half25(sum_w);
        avg_p_nxt  = half25(lr_sum);
        state_nxt  = ST_RATIO;
      end
      ST_RATIO: begin
        mul_en    = 1'b1;
        mul_a     = MUL_A_W'(radius_limit_r) + MUL_A_W'(1);
        mul_b     = den_r;
        state_nxt = ST_STORE;
      end
      ST_STORE: begin
        ram_we        = 1'b1;
        cnt_nxt       = cnt_r + CNT_W'(1);
        o_rst_nxt     = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_QMUL: begin
        seg_mm_nxt   = ram_rdata[PULSE_W-1:0];
        seg_p_nxt    = ram_rdata[2*PULSE_W-1:PULSE_W];
        seg_flag_nxt = ram_rdata[RAM_W-1];
        mul_en       = 1'b1;
        mul_a        = MUL_A_W'(pulses_per_mm_r);
        mul_b        = MUL_B_W'(mag24(ram_rdata[PULSE_W-1:0]));
        state_nxt    = ST_QOUT;
      end
      ST_QOUT: begin
        o_power_nxt   = seg_flag_r ? straight_pwr_r : curve_pwr_r;
        o_str_nxt     = seg_flag_r | (curve_pwr_r == straight_pwr_r);
        o_lng_nxt     = o_str_nxt && ($signed(seg_mm_r) > $signed({1'b0, long_mm_r}));
        o_done_nxt    = cur_s > target_s;
        o_mm_nxt      = seg_mm_r;
        o_p_nxt       = seg_p_r;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    l_r        <= l_nxt;
    r_r        <= r_nxt;
    mml_r      <= mml_nxt;
    mmr_r      <= mmr_nxt;
    num_r      <= num_nxt;
    den_r      <= den_nxt;
    avg_mm_r   <= avg_mm_nxt;
    avg_p_r    <= avg_p_nxt;
    seg_mm_r   <= seg_mm_nxt;
    seg_p_r    <= seg_p_nxt;
    seg_flag_r <= seg_flag_nxt;
    o_status_r <= o_status_nxt;
    o_rst_r    <= o_rst_nxt;
    o_power_r  <= o_power_nxt;
    o_done_r   <= o_done_nxt;
    o_str_r    <= o_str_nxt;
    o_lng_r    <= o_lng_nxt;
    o_mm_r     <= o_mm_nxt;
    o_p_r      <= o_p_nxt;
    o_cnt_r    <= cnt_nxt;
    o_idx_r    <= idx_nxt;
  end

  assign busy                 = (state_r != ST_IDLE);
  assign out_valid            = out_valid_r;
  assign out_status           = o_status_r;
  assign out_reset_encoders   = o_rst_r;
  assign out_target_power     = o_power_r;
  assign out_segment_done     = o_done_r;
  assign out_is_straight      = o_str_r;
  assign out_is_long_straight = o_lng_r;
  assign out_segment_mm       = o_mm_r;
  assign out_segment_pulses   = o_p_r;
  assign out_recorded_count   = o_cnt_r;
  assign out_current_index    = o_idx_r;

endmodule

`default_nettype wire
